// File: sv/miller_rabin_prime_test_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the primality tester
// Shared concurrent-assertion forms, clocked on the rising edge and
// disabled while the asynchronous reset is low.
// ---------------------------------------------------------------------------
`ifndef MILLER_RABIN_PRIME_TEST_DEFINES_SVH
`define MILLER_RABIN_PRIME_TEST_DEFINES_SVH

// Same-cycle implication.
`define MRPT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MRPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/mrpt_pkg.sv
// ---------------------------------------------------------------------------
// mrpt_pkg
// Shared constants, witness base table and status type of the tester.
// ---------------------------------------------------------------------------
`default_nettype none

package mrpt_pkg;

    localparam int VALUE_WIDTH_DEF = 62;
    localparam int NUM_BASES       = 9;
    localparam int BASE_IDX_W      = 4;
    localparam int BASE_W          = 5;
    localparam int OUT_TDATA_W     = 8;

    // Status of the modular multiplier as seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } mm_status_t;

    // Fixed witness bases 2 .. 23
    function automatic logic [BASE_W-1:0] base_value(input logic [BASE_IDX_W-1:0] idx);
        logic [BASE_W-1:0] v;
        case (idx)
            4'd0:    v = 5'd2;
            4'd1:    v = 5'd3;
            4'd2:    v = 5'd5;
            4'd3:    v = 5'd7;
            4'd4:    v = 5'd11;
            4'd5:    v = 5'd13;
            4'd6:    v = 5'd17;
            4'd7:    v = 5'd19;
            4'd8:    v = 5'd23;
            default: v = 5'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: sv/miller_rabin_prime_test.sv
// ---------------------------------------------------------------------------
// miller_rabin_prime_test
// Deterministic Miller-Rabin primality test over witness bases 2 .. 23,
// built on one shared bit-serial modular multiplier.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Contents
//  s_axis    in         candidate (VALUE_WIDTH bits, unsigned)
//  m_axis    out        is_prime (1 bit)
//
//  Work: a base needs up to two multiplications in the shared shift-and-add
//  unit per exponent bit plus up to s-1 squarings; values below four and
//  even values are decided in the idle state, without the multiplier.
//  Reset: rst_n clears the sequencer, the multiplier control and the output
//  valid at once. Stalls: a new candidate is taken as soon as the sequencer
//  is idle, even while the previous verdict waits on m_axis; a finished
//  verdict holds in the sequencer until the output register is free.
// ---------------------------------------------------------------------------
`default_nettype none

`include "miller_rabin_prime_test_defines.svh"

module miller_rabin_prime_test
    import mrpt_pkg::*;
#(
    parameter  int VALUE_WIDTH = VALUE_WIDTH_DEF,
    localparam int IN_TDATA_W  = ((VALUE_WIDTH + 7) / 8) * 8
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,   // [VALUE_WIDTH-1:0] candidate
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_TDATA_W-1:0]     m_axis_tdata    // [0] is_prime
);

    localparam int CNT_W = $clog2(VALUE_WIDTH);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_BASE_SEL,
        ST_EXP_STEP,
        ST_MULA_WAIT,
        ST_MULB_WAIT,
        ST_SQ_CHECK,
        ST_SQ_WAIT,
        ST_DONE
    } state_t;

    state_t                  state_reg;
    logic [VALUE_WIDTH-1:0]  n_reg;        // modulus under test
    logic [VALUE_WIDTH-1:0]  nm1_reg;      // n - 1
    logic [VALUE_WIDTH-1:0]  d_reg;        // odd part of n - 1
    logic [VALUE_WIDTH-1:0]  e_reg;        // exponent, shifted out LSB first
    logic [VALUE_WIDTH-1:0]  acc_reg;      // running power / x
    logic [VALUE_WIDTH-1:0]  b_reg;        // repeated square of the base
    logic [CNT_W-1:0]        s_reg;        // power of two in n - 1
    logic [CNT_W-1:0]        r_reg;        // squaring round
    logic [BASE_IDX_W-1:0]   base_idx_reg;
    logic                    verdict_reg;
    logic                    mm_start_reg;
    logic                    mm_start_next;
    logic [VALUE_WIDTH-1:0]  mm_x_reg;
    logic [VALUE_WIDTH-1:0]  mm_y_reg;
    logic                    out_valid_reg;
    logic [OUT_TDATA_W-1:0]  out_data_reg;

    logic [VALUE_WIDTH-1:0]  cand;
    logic [VALUE_WIDTH-1:0]  base_ext;
    logic [VALUE_WIDTH-1:0]  mm_product;
    mm_status_t              mm_status;

    assign cand     = s_axis_tdata[VALUE_WIDTH-1:0];
    assign base_ext = {{(VALUE_WIDTH-BASE_W){1'b0}}, base_value(base_idx_reg)};

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    mrpt_mulmod #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start_reg),
        .x       (mm_x_reg),
        .y       (mm_y_reg),
        .m       (n_reg),
        .product (mm_product),
        .status  (mm_status)
    );

    // Issue a multiplication: a new exponent bit, the square after a
    // multiply, or the next squaring round
    always_comb
    begin
        case (state_reg)
            ST_EXP_STEP:  mm_start_next = (e_reg != '0);
            ST_MULA_WAIT: mm_start_next = mm_status.done;
            ST_SQ_CHECK:  mm_start_next = (r_reg < s_reg);
            default:      mm_start_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            mm_start_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            base_idx_reg  <= '0;
            s_reg         <= '0;
            r_reg         <= '0;
            verdict_reg   <= 1'b0;
        end else begin
            mm_start_reg <= mm_start_next;
            // Drop the result once the downstream side has taken it, unless
            // a new verdict replaces it in the same cycle
            if (out_valid_reg && m_axis_tready && state_reg != ST_DONE) begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid) begin
                        n_reg   <= cand;
                        nm1_reg <= cand - 1'b1;
                        d_reg   <= cand - 1'b1;
                        s_reg   <= '0;
                        // Below two: not prime; two and three: prime; even: not prime
                        if (cand[VALUE_WIDTH-1:1] == '0) begin
                            verdict_reg <= 1'b0;
                            state_reg   <= ST_DONE;
                        end else if (cand[VALUE_WIDTH-1:2] == '0) begin
                            verdict_reg <= 1'b1;
                            state_reg   <= ST_DONE;
                        end else if (!cand[0]) begin
                            verdict_reg <= 1'b0;
                            state_reg   <= ST_DONE;
                        end else begin
                            state_reg <= ST_SPLIT;
                        end
                    end
                end

                ST_SPLIT:
                begin
                    // Strip one factor of two per cycle
                    if (!d_reg[0]) begin
                        d_reg <= d_reg >> 1;
                        s_reg <= s_reg + 1'b1;
                    end else begin
                        base_idx_reg <= '0;
                        state_reg    <= ST_BASE_SEL;
                    end
                end

                ST_BASE_SEL:
                begin
                    if (base_idx_reg == BASE_IDX_W'(NUM_BASES)) begin
                        verdict_reg <= 1'b1;
                        state_reg   <= ST_DONE;
                    end else if (n_reg > base_ext) begin
                        acc_reg   <= VALUE_WIDTH'(1);
                        b_reg     <= base_ext;
                        e_reg     <= d_reg;
                        state_reg <= ST_EXP_STEP;
                    end else begin
                        base_idx_reg <= base_idx_reg + 1'b1;
                    end
                end

                ST_EXP_STEP:
                begin
                    if (e_reg == '0) begin
                        // a^d is 1 or n-1: this base passes outright
                        if (acc_reg == VALUE_WIDTH'(1) || acc_reg == nm1_reg) begin
                            base_idx_reg <= base_idx_reg + 1'b1;
                            state_reg    <= ST_BASE_SEL;
                        end else begin
                            r_reg     <= CNT_W'(1);
                            state_reg <= ST_SQ_CHECK;
                        end
                    end else if (e_reg[0]) begin
                        mm_x_reg  <= acc_reg;
                        mm_y_reg  <= b_reg;
                        state_reg <= ST_MULA_WAIT;
                    end else begin
                        mm_x_reg  <= b_reg;
                        mm_y_reg  <= b_reg;
                        state_reg <= ST_MULB_WAIT;
                    end
                end

                ST_MULA_WAIT:
                begin
                    if (mm_status.done) begin
                        acc_reg   <= mm_product;
                        mm_x_reg  <= b_reg;
                        mm_y_reg  <= b_reg;
                        state_reg <= ST_MULB_WAIT;
                    end
                end

                ST_MULB_WAIT:
                begin
                    if (mm_status.done) begin
                        b_reg     <= mm_product;
                        e_reg     <= e_reg >> 1;
                        state_reg <= ST_EXP_STEP;
                    end
                end

                ST_SQ_CHECK:
                begin
                    if (r_reg < s_reg) begin
                        mm_x_reg  <= acc_reg;
                        mm_y_reg  <= acc_reg;
                        state_reg <= ST_SQ_WAIT;
                    end else begin
                        // Squarings exhausted without reaching n-1: composite
                        verdict_reg <= 1'b0;
                        state_reg   <= ST_DONE;
                    end
                end

                ST_SQ_WAIT:
                begin
                    if (mm_status.done) begin
                        acc_reg <= mm_product;
                        if (mm_product == nm1_reg) begin
                            base_idx_reg <= base_idx_reg + 1'b1;
                            state_reg    <= ST_BASE_SEL;
                        end else begin
                            r_reg     <= r_reg + 1'b1;
                            state_reg <= ST_SQ_CHECK;
                        end
                    end
                end

                ST_DONE:
                begin
                    // Hold the verdict until the output register is free
                    if (!out_valid_reg || m_axis_tready) begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {{(OUT_TDATA_W-1){1'b0}}, verdict_reg};
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `MRPT_ASSERT_NOW(a_done_in_wait, clk, rst_n, mm_status.done,
        (state_reg == ST_MULA_WAIT || state_reg == ST_MULB_WAIT || state_reg == ST_SQ_WAIT),
        "multiplier result outside a wait state")
    `MRPT_ASSERT_NOW(a_idle_mul_quiet, clk, rst_n, s_axis_tready, !mm_status.busy,
        "multiplier busy while idle")
    `MRPT_ASSERT_NEXT(a_out_drop, clk, rst_n,
        (m_axis_tvalid && m_axis_tready && state_reg != ST_DONE), !m_axis_tvalid,
        "result transfer not dropped")
    `MRPT_ASSERT_NOW(a_acc_reduced, clk, rst_n, state_reg == ST_EXP_STEP, acc_reg < n_reg,
        "power not reduced modulo n")

endmodule

`default_nettype wire

// File: sv/mrpt_mulmod.sv
// ---------------------------------------------------------------------------
// mrpt_mulmod
// Bit-serial modular multiplier: one multiplier bit per cycle, shift-and-add
// with a modular adder, so only two narrow add/compare paths per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

`include "miller_rabin_prime_test_defines.svh"

module mrpt_mulmod
    import mrpt_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,    // load operands and begin
    input  wire logic [VALUE_WIDTH-1:0] x,        // multiplicand, below m
    input  wire logic [VALUE_WIDTH-1:0] y,        // multiplier
    input  wire logic [VALUE_WIDTH-1:0] m,        // modulus
    output logic      [VALUE_WIDTH-1:0] product,  // valid while done is high
    output mm_status_t                  status
);

    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic [VALUE_WIDTH-1:0] x_reg,   x_next;
    logic [VALUE_WIDTH-1:0] y_reg,   y_next;
    logic [VALUE_WIDTH-1:0] m_reg;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;

    // (a + b) mod md, both operands below md
    function automatic logic [VALUE_WIDTH-1:0] add_mod(
        input logic [VALUE_WIDTH-1:0] a,
        input logic [VALUE_WIDTH-1:0] b,
        input logic [VALUE_WIDTH-1:0] md
    );
        logic [VALUE_WIDTH:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, md}) begin
            s = s - {1'b0, md};
        end
        return s[VALUE_WIDTH-1:0];
    endfunction

    always_comb
    begin
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next  = '0;
            x_next    = x;
            y_next    = y;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (y_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                if (y_reg[0]) begin
                    acc_next = add_mod(acc_reg, x_reg, m_reg);
                end
                x_next = add_mod(x_reg, x_reg, m_reg);
                y_next = y_reg >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        if (start) begin
            m_reg <= m;
        end
    end

    assign product     = acc_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

    `MRPT_ASSERT_NEXT(a_done_single, clk, rst_n, done_reg, !done_reg, "mulmod done held")
    `MRPT_ASSERT_NOW(a_no_restart, clk, rst_n, start, !busy_reg, "mulmod restarted while busy")
    `MRPT_ASSERT_NOW(a_reduced, clk, rst_n, done_reg, acc_reg < m_reg, "product not reduced")

endmodule

`default_nettype wire
